FILE: rtl/uvs_pkg.sv
package uvs_pkg;

	// Nibble tables: entry n is bits 8n+7..8n
	localparam logic [127:0] TAB_PREV_HIGH = {64'h4915012180808080, 64'h0202020202020202};
	localparam logic [127:0] TAB_PREV_LOW  = {64'hcbcbdbcbcbcbcbcb, 64'hcbcbcb8b8383a3e7};
	localparam logic [127:0] TAB_CUR_HIGH  = {64'h01010101babaaee6, 64'h0101010101010101};

	localparam logic [7:0] LEAD2_MIN  = 8'hC0;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] MUST23_BIT = 8'h80;

	typedef struct packed {
		logic tail_err;
		logic eos;
	} uvs_flags_t;

	function automatic logic [7:0] nib_lookup(input logic [127:0] tab, input logic [3:0] nib);
		return tab[{nib, 3'b000} +: 8];
	endfunction

endpackage

FILE: rtl/uvs_lane.sv
module uvs_lane
	import uvs_pkg::*;
(
	input  logic       en,
	input  logic [7:0] cur,
	input  logic [7:0] p1,
	input  logic [7:0] p2,
	input  logic [7:0] p3,
	output logic       err
);

	logic [7:0] sc;
	logic [7:0] must23;

	always_comb begin
		sc = nib_lookup(TAB_PREV_HIGH, p1[7:4]) &
		     nib_lookup(TAB_PREV_LOW, p1[3:0]) &
		     nib_lookup(TAB_CUR_HIGH, cur[7:4]);
		must23 = ((p2 >= LEAD3_MIN) || (p3 >= LEAD4_MIN)) ? MUST23_BIT : 8'h00;
		err = en && (sc != must23);
	end

endmodule

FILE: rtl/uvs_merge.sv
module uvs_merge
	import uvs_pkg::*;
#(
	parameter int LANES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [LANES-1:0] lane_err,
	input  uvs_flags_t       flags,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             error_seen,
	output logic             stream_done
);

	logic out_valid_q;
	logic err_acc_q;
	logic error_seen_q;
	logic stream_done_q;
	logic err;

	assign in_ready = !out_valid_q || out_ready;
	assign err = err_acc_q || (|lane_err) || (flags.tail_err && flags.eos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			err_acc_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
			// drop the sticky error when the stream closes
			if (in_valid)
				err_acc_q <= flags.eos ? 1'b0 : err;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			error_seen_q <= err;
			stream_done_q <= flags.eos;
		end
	end

	assign out_valid = out_valid_q;
	assign error_seen = error_seen_q;
	assign stream_done = stream_done_q;

endmodule

FILE: rtl/utf8_stream_validator_core.sv
// UTF-8 stream validator. Each transaction carries up to LANES stream bytes (byte zero first)
// and yields exactly one result: error_seen is the sticky verdict for the stream so far and
// stream_done echoes end_of_stream, after which all history clears for the next stream.
// The block takes one transaction per cycle back to back while output stalls do not hold it;
// the three-byte history register, updated by all lanes at once at each accepted transaction,
// sets that rate. Results pass the lane check stage, then the merge/output register, and stalls
// on the output side back-pressure the input only when both stages are full.
module utf8_stream_validator_core
	import uvs_pkg::*;
#(
	parameter int LANES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_bytes,
	input  logic [3:0]  byte_count,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        error_seen,
	output logic        stream_done
);

	localparam int SEQ = LANES + 3;

	logic [7:0] hist_q [3];
	logic [7:0] seq [SEQ];
	logic [7:0] nh [3];
	logic [3:0] cnt;
	logic       tail_err;
	logic       in_accept;
	logic       s1_ready;

	logic [LANES-1:0] lane_err;
	logic [LANES-1:0] lane_err_s1;
	uvs_flags_t       flags_s1;
	logic             valid_s1;

	assign cnt = (byte_count > 4'(LANES)) ? 4'(LANES) : byte_count;

	always_comb begin
		seq[0] = hist_q[2];
		seq[1] = hist_q[1];
		seq[2] = hist_q[0];
		for (int i = 0; i < LANES; i++)
			seq[i+3] = data_bytes[8*i +: 8];
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		uvs_lane u_lane (
			.en  (4'(g) < cnt),
			.cur (seq[g+3]),
			.p1  (seq[g+2]),
			.p2  (seq[g+1]),
			.p3  (seq[g]),
			.err (lane_err[g])
		);
	end

	// advance the history by the number of bytes taken
	always_comb begin
		nh[0] = hist_q[0];
		nh[1] = hist_q[1];
		nh[2] = hist_q[2];
		for (int k = 0; k <= LANES; k++) begin
			if (cnt == 4'(k)) begin
				nh[0] = seq[k+2];
				nh[1] = seq[k+1];
				nh[2] = seq[k];
			end
		end
		tail_err = (nh[0] >= LEAD2_MIN) || (nh[1] >= LEAD3_MIN) || (nh[2] >= LEAD4_MIN);
	end

	assign in_ready = !valid_s1 || s1_ready;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0] <= '0;
			hist_q[1] <= '0;
			hist_q[2] <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_accept) begin
				hist_q[0] <= end_of_stream ? 8'h00 : nh[0];
				hist_q[1] <= end_of_stream ? 8'h00 : nh[1];
				hist_q[2] <= end_of_stream ? 8'h00 : nh[2];
			end
			if (in_ready)
				valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			lane_err_s1 <= lane_err;
			flags_s1.tail_err <= tail_err;
			flags_s1.eos <= end_of_stream;
		end
	end

	uvs_merge #(
		.LANES (LANES)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s1),
		.in_ready    (s1_ready),
		.lane_err    (lane_err_s1),
		.flags       (flags_s1),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.error_seen  (error_seen),
		.stream_done (stream_done)
	);

endmodule

FILE: rtl/uvs_checker.sv
module uvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        error_seen,
	input logic        stream_done
);

	logic [1:0] pend_q;
	logic       sticky_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			sticky_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
			if (out_acc) begin
				if (stream_done)
					sticky_q <= 1'b0;
				else if (error_seen)
					sticky_q <= 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(error_seen) && $stable(stream_done))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a pending transaction");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more transactions in flight than pipeline stages");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sticky_q |-> error_seen)
		else $error("error flag dropped within a stream");

endmodule

bind utf8_stream_validator_core uvs_checker u_uvs_checker (.*);
